// ===== src/hrhp_pkg.sv =====
package hrhp_pkg;

  typedef enum logic [3:0] {
    PH_LIT      = 4'd0,
    PH_MAJOR    = 4'd1,
    PH_DOT      = 4'd2,
    PH_MINOR    = 4'd3,
    PH_SP1      = 4'd4,
    PH_CODE     = 4'd5,
    PH_SP2      = 4'd6,
    PH_REASON   = 4'd7,
    PH_LINE     = 4'd8,
    PH_BLANK_LF = 4'd9,
    PH_NAME     = 4'd10,
    PH_OWS      = 4'd11,
    PH_VALUE    = 4'd12,
    PH_HDR_LF   = 4'd13,
    PH_BODY     = 4'd14
  } phase_t;

  localparam logic [2:0] CLS_REASON = 3'd0;
  localparam logic [2:0] CLS_NAME   = 3'd1;
  localparam logic [2:0] CLS_VCHAR  = 3'd2;
  localparam logic [2:0] CLS_VWS    = 3'd3;
  localparam logic [2:0] CLS_BODY   = 3'd4;
  localparam logic [2:0] CLS_NONE   = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CHAR  = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] LIT_LEN   = 3'd5;
  localparam logic [2:0] CODE_LEN  = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_class;
    logic [3:0] http_major;
    logic [3:0] http_minor;
    logic [9:0] resp_status;
    logic       status_done;
    logic       header_done;
    logic       headers_end;
    logic [1:0] error_code;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] literal_index;
    logic [3:0] major_digit;
    logic [3:0] minor_digit;
    logic [9:0] code_accumulator;
    logic [7:0] held_reason_byte;
    logic       held_reason_valid;
    logic [1:0] error_flag;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:             PH_LIT,
    literal_index:     3'd0,
    major_digit:       4'd0,
    minor_digit:       4'd0,
    code_accumulator:  10'd0,
    held_reason_byte:  8'd0,
    held_reason_valid: 1'b0,
    error_flag:        ERR_NONE
  };

  // "HTTP/"
  function automatic logic [7:0] lit_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h50;
      3'd4:    ch = 8'h2f;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_HT);
  endfunction

endpackage

// ===== src/hrhp_step.sv =====
module hrhp_step (
  input  hrhp_pkg::state_t  state,
  input  hrhp_pkg::item_t   item,
  output hrhp_pkg::state_t  state_next,
  output hrhp_pkg::result_t result,
  output logic              has_result
);

  hrhp_pkg::state_t st;
  hrhp_pkg::state_t nx;
  logic [7:0]  c;
  logic [7:0]  ob;
  logic [2:0]  cls;
  logic        st_done;
  logic        hd_done;
  logic        h_end;
  logic        bad;
  logic [2:0]  idx_inc;
  logic [3:0]  digit;
  logic [9:0]  code_x10;

  assign c        = item.data_byte;
  assign st       = item.first_byte ? hrhp_pkg::STATE_RESET : state;
  assign idx_inc  = st.literal_index + 3'd1;
  assign digit    = 4'(c - hrhp_pkg::CH_ZERO);
  // code * 10, kept to 10 bits
  assign code_x10 = {st.code_accumulator[6:0], 3'b000} + {st.code_accumulator[8:0], 1'b0};

  always_comb begin
    nx      = st;
    ob      = 8'd0;
    cls     = hrhp_pkg::CLS_NONE;
    st_done = 1'b0;
    hd_done = 1'b0;
    h_end   = 1'b0;
    bad     = 1'b0;

    if (st.error_flag == hrhp_pkg::ERR_NONE) begin
      case (st.phase)
        hrhp_pkg::PH_LIT: begin
          if ((st.literal_index < hrhp_pkg::LIT_LEN) &&
              (c == hrhp_pkg::lit_char(st.literal_index))) begin
            if (idx_inc == hrhp_pkg::LIT_LEN) begin
              nx.literal_index = 3'd0;
              nx.phase         = hrhp_pkg::PH_MAJOR;
            end else begin
              nx.literal_index = idx_inc;
            end
          end else begin
            bad = 1'b1;
          end
        end
        hrhp_pkg::PH_MAJOR: begin
          if (hrhp_pkg::is_digit(c)) begin
            nx.major_digit = digit;
            nx.phase       = hrhp_pkg::PH_DOT;
          end else begin
            bad = 1'b1;
          end
        end
        hrhp_pkg::PH_DOT: begin
          if (c == hrhp_pkg::CH_DOT) nx.phase = hrhp_pkg::PH_MINOR;
          else bad = 1'b1;
        end
        hrhp_pkg::PH_MINOR: begin
          if (hrhp_pkg::is_digit(c)) begin
            nx.minor_digit = digit;
            nx.phase       = hrhp_pkg::PH_SP1;
          end else begin
            bad = 1'b1;
          end
        end
        hrhp_pkg::PH_SP1: begin
          if (c == hrhp_pkg::CH_SP) begin
            nx.phase            = hrhp_pkg::PH_CODE;
            nx.literal_index    = 3'd0;
            nx.code_accumulator = 10'd0;
          end else begin
            bad = 1'b1;
          end
        end
        hrhp_pkg::PH_CODE: begin
          if (hrhp_pkg::is_digit(c)) begin
            nx.code_accumulator = code_x10 + {6'd0, digit};
            if (idx_inc >= hrhp_pkg::CODE_LEN) begin
              nx.literal_index = 3'd0;
              nx.phase         = hrhp_pkg::PH_SP2;
            end else begin
              nx.literal_index = idx_inc;
            end
          end else begin
            bad = 1'b1;
          end
        end
        hrhp_pkg::PH_SP2: begin
          if (c == hrhp_pkg::CH_SP) begin
            nx.phase             = hrhp_pkg::PH_REASON;
            nx.held_reason_valid = 1'b0;
            nx.held_reason_byte  = 8'd0;
          end else begin
            bad = 1'b1;
          end
        end
        hrhp_pkg::PH_REASON: begin
          // reason bytes go out one late; the one before LF is dropped
          if (c == hrhp_pkg::CH_LF) begin
            if (st.held_reason_valid) begin
              nx.held_reason_valid = 1'b0;
              nx.held_reason_byte  = 8'd0;
              st_done              = 1'b1;
              nx.phase             = hrhp_pkg::PH_LINE;
            end else begin
              bad = 1'b1;
            end
          end else begin
            if (st.held_reason_valid) begin
              ob  = st.held_reason_byte;
              cls = hrhp_pkg::CLS_REASON;
            end
            nx.held_reason_byte  = c;
            nx.held_reason_valid = 1'b1;
          end
        end
        hrhp_pkg::PH_LINE: begin
          if (c == hrhp_pkg::CH_CR) begin
            nx.phase = hrhp_pkg::PH_BLANK_LF;
          end else if (c == hrhp_pkg::CH_COLON) begin
            nx.phase = hrhp_pkg::PH_OWS;
          end else begin
            ob       = c;
            cls      = hrhp_pkg::CLS_NAME;
            nx.phase = hrhp_pkg::PH_NAME;
          end
        end
        hrhp_pkg::PH_BLANK_LF: begin
          if (c == hrhp_pkg::CH_LF) begin
            h_end    = 1'b1;
            nx.phase = hrhp_pkg::PH_BODY;
          end else begin
            bad = 1'b1;
          end
        end
        hrhp_pkg::PH_NAME: begin
          if (c == hrhp_pkg::CH_COLON) begin
            nx.phase = hrhp_pkg::PH_OWS;
          end else begin
            ob  = c;
            cls = hrhp_pkg::CLS_NAME;
          end
        end
        hrhp_pkg::PH_OWS, hrhp_pkg::PH_VALUE: begin
          if (c == hrhp_pkg::CH_CR) begin
            nx.phase = hrhp_pkg::PH_HDR_LF;
          end else if (hrhp_pkg::is_ws(c)) begin
            // leading whitespace skipped, inner whitespace marked
            if (st.phase == hrhp_pkg::PH_VALUE) begin
              ob  = c;
              cls = hrhp_pkg::CLS_VWS;
            end
          end else if (c <= hrhp_pkg::CH_SP) begin
            bad = 1'b1;
          end else begin
            ob       = c;
            cls      = hrhp_pkg::CLS_VCHAR;
            nx.phase = hrhp_pkg::PH_VALUE;
          end
        end
        hrhp_pkg::PH_HDR_LF: begin
          if (c == hrhp_pkg::CH_LF) begin
            hd_done  = 1'b1;
            nx.phase = hrhp_pkg::PH_LINE;
          end else begin
            bad = 1'b1;
          end
        end
        hrhp_pkg::PH_BODY: begin
          ob  = c;
          cls = hrhp_pkg::CLS_BODY;
        end
        default: begin
          bad = 1'b1;
        end
      endcase

      if (bad) begin
        nx.error_flag = hrhp_pkg::ERR_CHAR;
        ob            = 8'd0;
        cls           = hrhp_pkg::CLS_NONE;
        st_done       = 1'b0;
        hd_done       = 1'b0;
        h_end         = 1'b0;
      end else if (item.last_byte && (nx.phase != hrhp_pkg::PH_BODY)) begin
        nx.error_flag = hrhp_pkg::ERR_TRUNC;
      end
    end
  end

  assign state_next = nx;
  assign has_result = (cls != hrhp_pkg::CLS_NONE) || st_done || hd_done || h_end ||
                      (nx.error_flag != hrhp_pkg::ERR_NONE);

  assign result.out_byte    = ob;
  assign result.byte_class  = cls;
  assign result.http_major  = nx.major_digit;
  assign result.http_minor  = nx.minor_digit;
  assign result.resp_status = nx.code_accumulator;
  assign result.status_done = st_done;
  assign result.header_done = hd_done;
  assign result.headers_end = h_end;
  assign result.error_code  = nx.error_flag;

endmodule

// ===== src/http_response_head_parser.sv =====
// HTTP response head parser, one byte per transaction. Each accepted byte sits
// in an input register, passes through the parse step and, if it yields a
// result, lands in the output register once that register is free. A new
// byte is taken every cycle while the result side keeps up; bytes that yield
// no result (literal, digits, ':', skipped whitespace, CR) never wait on the
// result side. Throughput is one byte per cycle unless the result side
// stalls. Errors are sticky until a byte with first_byte set.
module http_response_head_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  hrhp_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_ready,
  output hrhp_pkg::result_t  result
);

  logic              hold_valid;
  hrhp_pkg::item_t   hold_item;
  hrhp_pkg::state_t  state;
  hrhp_pkg::state_t  state_next;
  hrhp_pkg::result_t step_result;
  logic              step_has_result;
  logic              out_free;
  logic              step_fire;

  hrhp_step u_step (
    .state      (state),
    .item       (hold_item),
    .state_next (state_next),
    .result     (step_result),
    .has_result (step_has_result)
  );

  assign out_free   = !result_valid || result_ready;
  assign step_fire  = hold_valid && (!step_has_result || out_free);
  assign item_ready = !hold_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      state        <= hrhp_pkg::STATE_RESET;
    end else begin
      if (item_ready) begin
        hold_valid <= item_valid;
      end
      if (step_fire) begin
        state <= state_next;
      end
      if (step_fire && step_has_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold_item <= item;
    end
    if (step_fire && step_has_result) begin
      result <= step_result;
    end
  end

endmodule

// ===== src/hrhp_checker.sv =====
module hrhp_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input hrhp_pkg::result_t result
);

  logic any_pulse;
  assign any_pulse = result.status_done || result.header_done || result.headers_end;

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // an empty result only reports an error
  a_none_means_err: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.byte_class == hrhp_pkg::CLS_NONE) && !any_pulse
    |-> (result.error_code != hrhp_pkg::ERR_NONE))
    else $error("empty result without error");

  // line-end pulses are exclusive and carry no byte
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid && any_pulse
    |-> $onehot({result.status_done, result.header_done, result.headers_end}) &&
        (result.byte_class == hrhp_pkg::CLS_NONE) &&
        (result.error_code != hrhp_pkg::ERR_CHAR))
    else $error("bad line-end pulse");

  a_body_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.byte_class == hrhp_pkg::CLS_BODY || result.headers_end)
    |-> (result.error_code == hrhp_pkg::ERR_NONE))
    else $error("body byte with error");

endmodule

bind http_response_head_parser hrhp_checker u_hrhp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
